@@ design/oltbl_pkg.sv @@
package oltbl_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int WORD_W  = 64;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  typedef struct packed {
    logic req_load;
    logic walk_init_fwd;
    logic walk_init_up;
    logic walk_init_dn;
    logic scan_step;
    logic up_step;
    logic dn_step;
    logic rd_issue;
    logic rd_capture;
    logic set_ok;
    logic set_found;
    logic put_word;
    logic count_dec;
    logic out_load;
  } oltbl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             can_append;
    logic             can_insert;
    logic             can_read;
    logic             hit;
    logic             fwd_end;
    logic             up_end;
    logic             out_free;
  } oltbl_sts_t;

endpackage

@@ design/oltbl_ram.sv @@
module oltbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/oltbl_dpath.sv @@
module oltbl_dpath #(
  parameter int CAPACITY   = oltbl_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = oltbl_pkg::DEF_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [oltbl_pkg::CMD_W-1:0]     in_cmd,
  input  logic [oltbl_pkg::POS_W-1:0]     in_position,
  input  logic [oltbl_pkg::VALUE_W-1:0]   in_value,
  input  oltbl_pkg::oltbl_cmd_t           cmd,
  output oltbl_pkg::oltbl_sts_t           sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic                            out_found,
  output logic [oltbl_pkg::VALUE_W-1:0]   out_read_value,
  output logic [oltbl_pkg::COUNT_W-1:0]   out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > oltbl_pkg::POS_W) ? CW : oltbl_pkg::POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [oltbl_pkg::CMD_W-1:0]   op_r;
  logic [oltbl_pkg::POS_W-1:0]   pos_r;
  logic [DATA_WIDTH-1:0]         word_r;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 ptr_r, ptr_nxt;
  logic                          pend_r, pend_nxt;
  logic [CW-1:0]                 pidx_r, pidx_nxt;
  logic                          res_ok_r, res_found_r;
  logic [oltbl_pkg::VALUE_W-1:0] res_rdata_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_ok_r, out_found_r;
  logic [oltbl_pkg::VALUE_W-1:0] out_rdata_r;
  logic [oltbl_pkg::COUNT_W-1:0] out_count_r;

  logic [oltbl_pkg::WORD_W-1:0]  value_x, rdata_x;
  logic [DATA_WIDTH-1:0]         ram_rdata, ram_wdata;
  logic [AW-1:0]                 ram_raddr, ram_waddr;
  logic                          ram_re, ram_we;
  logic [CW-1:0]                 ins_pos, ptr_m1, pidx_p1, pidx_m1;
  logic [XW-1:0]                 pos_x, cnt_x;
  logic                          out_free;

  assign value_x = oltbl_pkg::WORD_W'(in_value);
  assign rdata_x = oltbl_pkg::WORD_W'(ram_rdata);
  assign pos_x   = XW'(pos_r);
  assign cnt_x   = XW'(count_r);
  assign ins_pos = (op_r == oltbl_pkg::CMD_APPEND) ? count_r : CW'(pos_r);
  assign ptr_m1  = ptr_r - 1'b1;
  assign pidx_p1 = pidx_r + 1'b1;
  assign pidx_m1 = pidx_r - 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.can_append = count_r < CAP_C;
    sts.can_insert = (pos_x <= cnt_x) && (count_r < CAP_C);
    sts.can_read   = pos_x < cnt_x;
    sts.hit        = pend_r && (ram_rdata == word_r);
    sts.fwd_end    = (ptr_r >= count_r) && !pend_r;
    sts.up_end     = (ptr_r <= ins_pos) && !pend_r;
    sts.out_free   = out_free;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if ((cmd.scan_step || cmd.dn_step) && (ptr_r < count_r)) begin
      ram_re    = 1'b1;
      ram_raddr = ptr_r[AW-1:0];
    end
    if (cmd.up_step && (ptr_r > ins_pos)) begin
      ram_re    = 1'b1;
      ram_raddr = ptr_m1[AW-1:0];
    end
    if (cmd.rd_issue) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(pos_r);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    if (cmd.up_step && pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pidx_p1[AW-1:0];
    end
    if (cmd.dn_step && pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pidx_m1[AW-1:0];
    end
    if (cmd.put_word) begin
      ram_we    = 1'b1;
      ram_waddr = ins_pos[AW-1:0];
      ram_wdata = word_r;
    end
  end

  always_comb begin
    ptr_nxt  = ptr_r;
    pend_nxt = pend_r;
    pidx_nxt = pidx_r;
    if (cmd.req_load || cmd.walk_init_fwd) begin
      ptr_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (cmd.walk_init_up) begin
      ptr_nxt  = count_r;
      pend_nxt = 1'b0;
    end else if (cmd.walk_init_dn) begin
      ptr_nxt  = pidx_p1;
      pend_nxt = 1'b0;
    end else if (cmd.scan_step || cmd.dn_step) begin
      if (ptr_r < count_r) begin
        pidx_nxt = ptr_r;
        pend_nxt = 1'b1;
        ptr_nxt  = ptr_r + 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
    end else if (cmd.up_step) begin
      if (ptr_r > ins_pos) begin
        pidx_nxt = ptr_m1;
        pend_nxt = 1'b1;
        ptr_nxt  = ptr_m1;
      end else begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.put_word) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.count_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    pidx_r <= pidx_nxt;
    if (cmd.req_load) begin
      op_r        <= in_cmd;
      pos_r       <= in_position;
      word_r      <= value_x[DATA_WIDTH-1:0];
      res_ok_r    <= 1'b0;
      res_found_r <= 1'b0;
      res_rdata_r <= '0;
    end else begin
      if (cmd.set_ok) begin
        res_ok_r <= 1'b1;
      end
      if (cmd.set_found) begin
        res_found_r <= 1'b1;
      end
      if (cmd.rd_capture) begin
        res_rdata_r <= rdata_x[oltbl_pkg::VALUE_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_ok_r    <= res_ok_r;
      out_found_r <= res_found_r;
      out_rdata_r <= res_rdata_r;
      out_count_r <= oltbl_pkg::COUNT_W'(count_r);
    end
  end

  oltbl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_rdata_r;
  assign out_count      = out_count_r;

endmodule

@@ design/oltbl_ctrl.sv @@
module oltbl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  oltbl_pkg::oltbl_sts_t sts,
  output oltbl_pkg::oltbl_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_SHUP     = 7'b0001000,
    ST_SHDN     = 7'b0010000,
    ST_RDWAIT   = 7'b0100000,
    ST_DONE     = 7'b1000000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.op) inside
          oltbl_pkg::CMD_APPEND: begin
            if (sts.can_append) begin
              cmd.walk_init_up = 1'b1;
              state_nxt        = ST_SHUP;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          oltbl_pkg::CMD_INSERT: begin
            if (sts.can_insert) begin
              cmd.walk_init_up = 1'b1;
              state_nxt        = ST_SHUP;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          oltbl_pkg::CMD_REMOVE, oltbl_pkg::CMD_SEARCH: begin
            cmd.walk_init_fwd = 1'b1;
            state_nxt         = ST_SCAN;
          end
          oltbl_pkg::CMD_READ: begin
            if (sts.can_read) begin
              cmd.rd_issue = 1'b1;
              state_nxt    = ST_RDWAIT;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.set_ok    = 1'b1;
          cmd.set_found = 1'b1;
          if (sts.op == oltbl_pkg::CMD_REMOVE) begin
            cmd.walk_init_dn = 1'b1;
            state_nxt        = ST_SHDN;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (sts.fwd_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SHUP: begin
        if (sts.up_end) begin
          cmd.put_word = 1'b1;
          cmd.set_ok   = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.up_step = 1'b1;
        end
      end
      ST_SHDN: begin
        if (sts.fwd_end) begin
          cmd.count_dec = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd.dn_step = 1'b1;
        end
      end
      ST_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        cmd.set_ok     = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

@@ design/ordered_list_table_engine.sv @@
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    in_cmd, in_position, in_value
// out_     output     out_valid / out_stall  out_ok, out_found, out_read_value, out_count
//
// One request is worked at a time; the entry RAM has one read and one write port and
// moves one entry per cycle. Append writes at the tail and read fetches one entry;
// search scans from entry 0 to the match or the end, insert shifts the entries from
// the position up by one, and remove scans for the match, then shifts later entries
// down. Reset clears the entry count and the control state; entry contents stay
// undefined. A held response does not block the next request, which waits only
// before loading its own response.
module ordered_list_table_engine #(
  parameter int CAPACITY   = oltbl_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = oltbl_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oltbl_pkg::CMD_W-1:0]   in_cmd,
  input  logic [oltbl_pkg::POS_W-1:0]   in_position,
  input  logic [oltbl_pkg::VALUE_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic                          out_found,
  output logic [oltbl_pkg::VALUE_W-1:0] out_read_value,
  output logic [oltbl_pkg::COUNT_W-1:0] out_count
);

  oltbl_pkg::oltbl_cmd_t ctl_cmd;
  oltbl_pkg::oltbl_sts_t dp_sts;

  oltbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  oltbl_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_value       (in_value),
    .cmd            (ctl_cmd),
    .sts            (dp_sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a request was still in progress");

  a_found_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_ok)
    else $error("response reports a match without success");

  a_rdata_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_value != '0)) |-> out_ok)
    else $error("response carries read data for a failed request");

  a_walk_cmds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctl_cmd.scan_step, ctl_cmd.up_step, ctl_cmd.dn_step,
                ctl_cmd.rd_issue, ctl_cmd.put_word}) <= 1)
    else $error("more than one entry RAM operation commanded in one cycle");

endmodule

@@ sim/tb_ordered_list_table_engine.sv @@
module tb_ordered_list_table_engine;

  localparam int CAPACITY = oltbl_pkg::DEF_CAPACITY;
  localparam logic [oltbl_pkg::CMD_W-1:0]   CMD_FIRST_UNUSED = 3'd5;
  localparam logic [oltbl_pkg::CMD_W-1:0]   CMD_LAST_CODE    = 3'd7;
  localparam logic [oltbl_pkg::POS_W-1:0]   POS_TOP          = 7'd127;
  localparam logic [oltbl_pkg::VALUE_W-1:0] WORD_ONES        = 32'hFFFF_FFFF;
  localparam int RANDOM_REQUESTS = 1125;
  localparam int PHASE_LEN       = 150;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 150;
  localparam int MODE_GROW   = 0;
  localparam int MODE_MIXED  = 1;
  localparam int MODE_SHRINK = 2;

  typedef struct packed {
    logic                          ok;
    logic                          found;
    logic [oltbl_pkg::VALUE_W-1:0] read_value;
    logic [oltbl_pkg::COUNT_W-1:0] count;
  } list_response_t;

  class list_mirror;
    logic [oltbl_pkg::VALUE_W-1:0] slots [CAPACITY];
    int unsigned                   used;
    list_response_t                expected_responses [$];
    int                            mismatches;

    function new();
      used = 0;
      mismatches = 0;
    endfunction

    function int find(logic [oltbl_pkg::VALUE_W-1:0] w);
      int i;
      for (i = 0; i < int'(used); i++) begin
        if (slots[i] === w) return i;
      end
      return -1;
    endfunction

    function void apply_request(logic [oltbl_pkg::CMD_W-1:0] c,
                                logic [oltbl_pkg::POS_W-1:0] p,
                                logic [oltbl_pkg::VALUE_W-1:0] w);
      list_response_t r;
      int i;
      int hit;
      r = '0;
      case (c)
        oltbl_pkg::CMD_APPEND: begin
          if (used < CAPACITY) begin
            slots[used] = w;
            used++;
            r.ok = 1'b1;
          end
        end
        oltbl_pkg::CMD_INSERT: begin
          if (p <= used && used < CAPACITY) begin
            for (i = int'(used); i > int'(p); i--) slots[i] = slots[i-1];
            slots[p] = w;
            used++;
            r.ok = 1'b1;
          end
        end
        oltbl_pkg::CMD_REMOVE: begin
          hit = find(w);
          if (hit >= 0) begin
            for (i = hit; i + 1 < int'(used); i++) slots[i] = slots[i+1];
            used--;
            r.ok = 1'b1;
            r.found = 1'b1;
          end
        end
        oltbl_pkg::CMD_SEARCH: begin
          if (find(w) >= 0) begin
            r.ok = 1'b1;
            r.found = 1'b1;
          end
        end
        oltbl_pkg::CMD_READ: begin
          if (p < used) begin
            r.read_value = slots[p];
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = used[oltbl_pkg::COUNT_W-1:0];
      expected_responses.push_back(r);
    endfunction

    function void match_response(list_response_t got);
      list_response_t want;
      if (expected_responses.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: response with nothing pending: ok=%b found=%b rd=%h count=%0d",
                   $time, got.ok, got.found, got.read_value, got.count);
        mismatches++;
        return;
      end
      want = expected_responses.pop_front();
      if (got.ok !== want.ok || got.found !== want.found ||
          got.read_value !== want.read_value || got.count !== want.count) begin
        if (mismatches < 10)
          $display("%0t: expected ok=%b found=%b rd=%h count=%0d, got ok=%b found=%b rd=%h count=%0d",
                   $time, want.ok, want.found, want.read_value, want.count,
                   got.ok, got.found, got.read_value, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic [oltbl_pkg::CMD_W-1:0]   in_cmd      = '0;
  logic [oltbl_pkg::POS_W-1:0]   in_position = '0;
  logic [oltbl_pkg::VALUE_W-1:0] in_value    = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic                          out_ok;
  logic                          out_found;
  logic [oltbl_pkg::VALUE_W-1:0] out_read_value;
  logic [oltbl_pkg::COUNT_W-1:0] out_count;

  bit         calm       = 1'b0;
  bit         hold_asked = 1'b0;
  list_mirror lists;

  ordered_list_table_engine u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic issue(logic [oltbl_pkg::CMD_W-1:0] c, logic [oltbl_pkg::POS_W-1:0] p,
                       logic [oltbl_pkg::VALUE_W-1:0] w);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= c;
    in_position <= p;
    in_value    <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lists.apply_request(c, p, w);
  endtask

  function automatic logic [oltbl_pkg::VALUE_W-1:0] random_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return $urandom_range(7);
    if (roll < 35) return '0;
    if (roll < 40) return WORD_ONES;
    return $urandom();
  endfunction

  function automatic void pick_request(int mode, output logic [oltbl_pkg::CMD_W-1:0] c,
                                       output logic [oltbl_pkg::POS_W-1:0] p,
                                       output logic [oltbl_pkg::VALUE_W-1:0] w);
    int roll;
    int n;
    int cut [5];
    n = int'(lists.used);
    roll = $urandom_range(99);
    case (mode)
      MODE_GROW:  cut = '{35, 65, 75, 85, 95};
      MODE_SHRINK: cut = '{10, 20, 60, 75, 92};
      default:    cut = '{20, 40, 60, 75, 92};
    endcase
    w = random_word();
    p = oltbl_pkg::POS_W'($urandom_range(POS_TOP));
    if (roll < cut[0]) begin
      c = oltbl_pkg::CMD_APPEND;
    end else if (roll < cut[1]) begin
      c = oltbl_pkg::CMD_INSERT;
      if ($urandom_range(99) < 85) p = oltbl_pkg::POS_W'($urandom_range(n));
    end else if (roll < cut[3]) begin
      c = (roll < cut[2]) ? oltbl_pkg::CMD_REMOVE : oltbl_pkg::CMD_SEARCH;
      if (n > 0 && $urandom_range(99) < 75) w = lists.slots[$urandom_range(n - 1)];
    end else if (roll < cut[4]) begin
      c = oltbl_pkg::CMD_READ;
      if (n > 0 && $urandom_range(99) < 80) p = oltbl_pkg::POS_W'($urandom_range(n - 1));
    end else begin
      c = oltbl_pkg::CMD_W'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED));
    end
  endfunction

  initial begin : response_side
    int hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        lists.match_response({out_ok, out_found, out_read_value, out_count});
      if (hold_asked) begin
        hold_asked = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!calm && $urandom_range(99) < 38);
      end
    end
  end

  initial begin : request_side
    int k;
    int u;
    logic [oltbl_pkg::CMD_W-1:0]   c;
    logic [oltbl_pkg::POS_W-1:0]   p;
    logic [oltbl_pkg::VALUE_W-1:0] w;
    lists = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // An empty table fails reads, removes and searches.
    issue(oltbl_pkg::CMD_READ, '0, '0);
    issue(oltbl_pkg::CMD_READ, POS_TOP, WORD_ONES);
    issue(oltbl_pkg::CMD_REMOVE, '0, '0);
    issue(oltbl_pkg::CMD_SEARCH, '0, WORD_ONES);
    issue(oltbl_pkg::CMD_INSERT, '0, WORD_ONES);
    issue(oltbl_pkg::CMD_INSERT, 7'd2, 32'h1111_2222);
    issue(oltbl_pkg::CMD_APPEND, '0, '0);
    issue(oltbl_pkg::CMD_APPEND, POS_TOP, 32'hA5A5_5A5A);
    issue(oltbl_pkg::CMD_INSERT, 7'd1, 32'h8000_0001);
    issue(oltbl_pkg::CMD_INSERT, 7'd4, 32'd1);
    issue(oltbl_pkg::CMD_INSERT, POS_TOP, 32'd9);
    issue(oltbl_pkg::CMD_READ, '0, '0);
    issue(oltbl_pkg::CMD_READ, 7'd4, '0);
    issue(oltbl_pkg::CMD_READ, 7'd5, '0);
    issue(oltbl_pkg::CMD_SEARCH, '0, 32'd1);
    issue(oltbl_pkg::CMD_SEARCH, '0, 32'h1234_5678);
    issue(oltbl_pkg::CMD_REMOVE, '0, '0);
    issue(oltbl_pkg::CMD_REMOVE, '0, WORD_ONES);
    issue(oltbl_pkg::CMD_REMOVE, '0, 32'h5A5A_A5A5);
    issue(oltbl_pkg::CMD_READ, 7'd1, '0);
    for (u = int'(CMD_FIRST_UNUSED); u <= int'(CMD_LAST_CODE); u++)
      issue(u[oltbl_pkg::CMD_W-1:0], POS_TOP, WORD_ONES);

    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      calm = (k >= 400 && k < 550);
      if (k == 700) hold_asked = 1'b1;
      pick_request((k / PHASE_LEN) % 3, c, p, w);
      issue(c, p, w);
    end
    in_valid <= 1'b0;

    while (lists.expected_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (lists.mismatches == 0 && lists.expected_responses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ ordered_list_table_engine.f @@
design/oltbl_pkg.sv
design/oltbl_ram.sv
design/oltbl_dpath.sv
design/oltbl_ctrl.sv
design/ordered_list_table_engine.sv
sim/tb_ordered_list_table_engine.sv
